// ----- rtl/core/qtu_pkg.sv -----
// Shared types and character constants for the quoted token unescape block.
`default_nettype none

package qtu_pkg;

    localparam int CHAR_W  = 16;
    localparam int NUM_RES = 4;
    localparam int IDX_W   = 2;

    localparam logic [CHAR_W-1:0] CH_BSL   = 16'h005C;
    localparam logic [CHAR_W-1:0] CH_SQUOT = 16'h0027;
    localparam logic [CHAR_W-1:0] CH_DQUOT = 16'h0022;
    localparam logic [CHAR_W-1:0] CH_LC_T  = 16'h0074;
    localparam logic [CHAR_W-1:0] CH_LC_N  = 16'h006E;
    localparam logic [CHAR_W-1:0] CH_LC_R  = 16'h0072;
    localparam logic [CHAR_W-1:0] CH_LC_U  = 16'h0075;
    localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;
    localparam logic [CHAR_W-1:0] CH_LF    = 16'h000A;
    localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;

    // All results caused by one input character.
    typedef struct packed {
        logic [NUM_RES-1:0][CHAR_W-1:0] chars;
        logic [NUM_RES-1:0]             valid;
        logic [IDX_W-1:0]               last_idx;
        logic                           any;
        logic                           token_end;
    } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/qtu_decode.sv -----
// Per-character unescape decoder: token state registers and result assembly.
`default_nettype none

module qtu_decode #(
    parameter int MAX_HEX_DIGITS = 4
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      step,
    input  wire logic [qtu_pkg::CHAR_W-1:0] char_in,
    input  wire logic                      is_last,
    output qtu_pkg::res_t                  res
);

    localparam int HCW = $clog2(MAX_HEX_DIGITS + 1);
    localparam logic [HCW-1:0] MAXD = HCW'(MAX_HEX_DIGITS);

    localparam logic [1:0] PH_TEXT = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_HEX  = 2'd2;

    typedef struct packed {
        logic [qtu_pkg::NUM_RES-1:0][qtu_pkg::CHAR_W-1:0] chars;
        logic [qtu_pkg::NUM_RES-1:0]                      valid;
        logic [2:0]                                       n;
        logic [1:0]                                       phase;
        logic [HCW-1:0]                                   hcount;
        logic [qtu_pkg::CHAR_W-1:0]                       hval;
    } work_t;

    logic                       at_start_reg, at_start_next;
    logic                       quoted_reg, quoted_next;
    logic [qtu_pkg::CHAR_W-1:0] quote_reg, quote_next;
    logic [1:0]                 phase_reg, phase_next;
    logic [HCW-1:0]             hcount_reg, hcount_next;
    logic [qtu_pkg::CHAR_W-1:0] hval_reg, hval_next;
    work_t                      w;

    function automatic work_t f_emit(work_t wi, logic [qtu_pkg::CHAR_W-1:0] c, logic v);
        work_t wo;
        wo = wi;
        if (wo.n < 3'd4)
        begin
            wo.chars[wo.n[1:0]] = c;
            wo.valid[wo.n[1:0]] = v;
            wo.n                = wo.n + 3'd1;
        end
        return wo;
    endfunction

    function automatic logic [qtu_pkg::CHAR_W-1:0] f_digit_char(logic [3:0] v);
        logic [qtu_pkg::CHAR_W-1:0] r;
        if (v < 4'd10)
            r = 16'h0030 + {12'd0, v};
        else
            r = 16'h0061 + {12'd0, v} - 16'd10;
        return r;
    endfunction

    // Emits whatever an unfinished escape stands for and returns to plain text.
    function automatic work_t f_flush(work_t wi);
        work_t wo;
        wo = wi;
        if (wo.phase == PH_ESC)
        begin
            wo = f_emit(wo, qtu_pkg::CH_BSL, 1'b1);
        end
        else if (wo.phase == PH_HEX)
        begin
            if (wo.hcount >= HCW'(2))
            begin
                wo = f_emit(wo, wo.hval, 1'b1);
            end
            else
            begin
                wo = f_emit(wo, qtu_pkg::CH_BSL, 1'b1);
                wo = f_emit(wo, qtu_pkg::CH_LC_U, 1'b1);
                if (wo.hcount == HCW'(1))
                    wo = f_emit(wo, f_digit_char(wo.hval[3:0]), 1'b1);
            end
        end
        wo.phase  = PH_TEXT;
        wo.hcount = '0;
        wo.hval   = '0;
        return wo;
    endfunction

    function automatic work_t f_text(work_t wi, logic [qtu_pkg::CHAR_W-1:0] c);
        work_t wo;
        wo = wi;
        if (c == qtu_pkg::CH_BSL)
            wo.phase = PH_ESC;
        else
            wo = f_emit(wo, c, 1'b1);
        return wo;
    endfunction

    function automatic work_t f_body(work_t wi, logic [qtu_pkg::CHAR_W-1:0] c,
                                     logic [qtu_pkg::CHAR_W-1:0] q);
        work_t      wo;
        logic       dig_ok;
        logic [3:0] dig;
        wo     = wi;
        dig_ok = 1'b0;
        dig    = 4'd0;
        if (c >= 16'h0030 && c <= 16'h0039)
        begin
            dig_ok = 1'b1;
            dig    = c[3:0];
        end
        else if (c >= 16'h0061 && c <= 16'h0066)
        begin
            dig_ok = 1'b1;
            dig    = c[3:0] + 4'd9;
        end
        case (wo.phase)
            PH_TEXT:
            begin
                wo = f_text(wo, c);
            end
            PH_ESC:
            begin
                wo.phase = PH_TEXT;
                if (c == qtu_pkg::CH_BSL)
                    wo = f_emit(wo, qtu_pkg::CH_BSL, 1'b1);
                else if (c == qtu_pkg::CH_LC_T)
                    wo = f_emit(wo, qtu_pkg::CH_TAB, 1'b1);
                else if (c == qtu_pkg::CH_LC_N)
                    wo = f_emit(wo, qtu_pkg::CH_LF, 1'b1);
                else if (c == qtu_pkg::CH_LC_R)
                    wo = f_emit(wo, qtu_pkg::CH_CR, 1'b1);
                else if (c == q)
                    wo = f_emit(wo, c, 1'b1);
                else if (c == qtu_pkg::CH_LC_U)
                begin
                    wo.phase  = PH_HEX;
                    wo.hcount = '0;
                    wo.hval   = '0;
                end
                else
                begin
                    wo = f_emit(wo, qtu_pkg::CH_BSL, 1'b1);
                    wo = f_emit(wo, c, 1'b1);
                end
            end
            default:
            begin
                if (dig_ok && wo.hcount < MAXD)
                begin
                    wo.hval   = {wo.hval[qtu_pkg::CHAR_W-5:0], dig};
                    wo.hcount = wo.hcount + HCW'(1);
                    if (wo.hcount >= MAXD)
                    begin
                        wo        = f_emit(wo, wo.hval, 1'b1);
                        wo.phase  = PH_TEXT;
                        wo.hcount = '0;
                        wo.hval   = '0;
                    end
                end
                else
                begin
                    wo = f_flush(wo);
                    wo = f_text(wo, c);
                end
            end
        endcase
        return wo;
    endfunction

    always_comb
    begin
        w             = '0;
        w.phase       = phase_reg;
        w.hcount      = hcount_reg;
        w.hval        = hval_reg;
        at_start_next = at_start_reg;
        quoted_next   = quoted_reg;
        quote_next    = quote_reg;

        if (at_start_reg)
        begin
            at_start_next = 1'b0;
            w.phase       = PH_TEXT;
            w.hcount      = '0;
            w.hval        = '0;
            if (char_in == qtu_pkg::CH_SQUOT || char_in == qtu_pkg::CH_DQUOT)
            begin
                quoted_next = 1'b1;
                quote_next  = char_in;
            end
            else
            begin
                quoted_next = 1'b0;
                quote_next  = '0;
                w           = f_emit(w, char_in, 1'b1);
            end
        end
        else if (!quoted_reg)
        begin
            w = f_emit(w, char_in, 1'b1);
        end
        else if (is_last && char_in == quote_reg)
        begin
            // The closing quote is dropped; a pending escape ends before it.
            w = f_flush(w);
        end
        else
        begin
            w = f_body(w, char_in, quote_reg);
            if (is_last)
                w = f_flush(w);
        end

        // A token that ends without any character still signals its end.
        if (is_last && w.n == 3'd0)
            w = f_emit(w, '0, 1'b0);

        phase_next  = w.phase;
        hcount_next = w.hcount;
        hval_next   = w.hval;
        if (is_last)
        begin
            at_start_next = 1'b1;
            quoted_next   = 1'b0;
            quote_next    = '0;
            phase_next    = PH_TEXT;
            hcount_next   = '0;
            hval_next     = '0;
        end

        res.chars     = w.chars;
        res.valid     = w.valid;
        res.any       = (w.n != 3'd0);
        res.last_idx  = w.n[1:0] - 2'd1;
        res.token_end = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg <= 1'b1;
            quoted_reg   <= 1'b0;
            quote_reg    <= '0;
            phase_reg    <= PH_TEXT;
            hcount_reg   <= '0;
            hval_reg     <= '0;
        end
        else if (step)
        begin
            at_start_reg <= at_start_next;
            quoted_reg   <= quoted_next;
            quote_reg    <= quote_next;
            phase_reg    <= phase_next;
            hcount_reg   <= hcount_next;
            hval_reg     <= hval_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/quoted_token_unescape.sv -----
// Quoted token unescape: top level with input register, decoder and result buffer.
// A request waits in the input register until the result buffer is free; its results
// then drive m_tdata. Throughput: one character per cycle while m_tready is high and
// each character yields at most one result; up to four results go out one by one.
// Reset (rst_n low, asynchronous) empties both stages and returns to token start.
`default_nettype none

module quoted_token_unescape #(
    parameter int MAX_HEX_DIGITS = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] char_in
    input  wire logic        s_tlast,   // is_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] char_out
    output logic             m_tlast,   // run_last
    output logic [1:0]       m_tuser    // [0] char_valid, [1] token_end
);

    logic                               in_vld_reg, in_vld_next;
    logic [qtu_pkg::CHAR_W-1:0]         in_char_reg;
    logic                               in_last_reg;
    logic                               out_vld_reg, out_vld_next;
    logic [qtu_pkg::IDX_W-1:0]          idx_reg, idx_next;
    qtu_pkg::res_t                      res_reg;
    qtu_pkg::res_t                      dec_res;
    logic                               in_take;
    logic                               out_take;
    logic                               out_done;
    logic                               move;

    assign out_take = out_vld_reg && m_tready;
    assign out_done = out_take && (idx_reg == res_reg.last_idx);
    assign move     = in_vld_reg && (!out_vld_reg || out_done);
    assign s_tready = !in_vld_reg || move;
    assign in_take  = s_tvalid && s_tready;

    qtu_decode #(
        .MAX_HEX_DIGITS(MAX_HEX_DIGITS)
    ) u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (move),
        .char_in (in_char_reg),
        .is_last (in_last_reg),
        .res     (dec_res)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
            in_vld_next = 1'b1;
        else if (move)
            in_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        idx_next     = idx_reg;
        if (move)
        begin
            // A character that yields nothing leaves the buffer empty.
            out_vld_next = dec_res.any;
            idx_next     = '0;
        end
        else if (out_done)
        begin
            out_vld_next = 1'b0;
            idx_next     = '0;
        end
        else if (out_take)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (move)
            res_reg <= dec_res;
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = res_reg.chars[idx_reg];
    assign m_tlast    = (idx_reg == res_reg.last_idx);
    assign m_tuser[0] = res_reg.valid[idx_reg];
    assign m_tuser[1] = res_reg.token_end && (idx_reg == res_reg.last_idx);

endmodule

`default_nettype wire

// ----- bench/token_decode_checker.sv -----
// Watches both streams of the unescape block, predicts each decoded character and compares.
`timescale 1ns / 100ps

module token_decode_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] char_in
    input  wire logic        s_tlast,   // is_last
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // [15:0] char_out
    input  wire logic        m_tlast,   // run_last
    input  wire logic [1:0]  m_tuser,   // [0] char_valid, [1] token_end
    output int               fail_count,
    output int               owed_count
);

    localparam int          MAX_HEX   = 4;
    localparam int          MAX_PRINT = 40;
    localparam logic [15:0] CH_ZERO   = 16'h0030;
    localparam logic [15:0] CH_LC_A   = 16'h0061;

    typedef enum logic [1:0] {
        ESC_TEXT,
        ESC_BSL,
        ESC_HEX
    } esc_phase_e;

    typedef struct packed {
        logic [15:0] char_out;
        logic        char_valid;
        logic        run_last;
        logic        token_end;
    } decoded_t;

    decoded_t    owed_chars [$];
    decoded_t    want;

    logic        at_start;
    logic        in_quotes;
    logic [15:0] open_quote;
    esc_phase_e  esc_phase;
    int          hex_cnt;
    logic [15:0] hex_acc;

    // Characters produced by the request being predicted.
    logic [15:0] step_char [8];
    logic        step_valid [8];
    int          step_n;

    initial
    begin
        fail_count = 0;
        owed_count = 0;
    end

    task automatic report_mismatch(input string what);
        if (fail_count < MAX_PRINT)
            $display("%0t ns: mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic reset_decoder();
        at_start   = 1'b1;
        in_quotes  = 1'b0;
        open_quote = '0;
        esc_phase  = ESC_TEXT;
        hex_cnt    = 0;
        hex_acc    = '0;
    endtask

    task automatic add_char(input logic [15:0] c, input logic v);
        if (step_n < 8)
        begin
            step_char[step_n]  = c;
            step_valid[step_n] = v;
            step_n++;
        end
    endtask

    function automatic int hex_nibble(input logic [15:0] c);
        if (c >= CH_ZERO && c <= CH_ZERO + 9)
            return int'(c - CH_ZERO);
        if (c >= CH_LC_A && c <= CH_LC_A + 5)
            return int'(c - CH_LC_A) + 10;
        return -1;
    endfunction

    // Whatever an unfinished escape stands for once the body has ended.
    task automatic flush_escape();
        case (esc_phase)
            ESC_BSL:
                add_char(qtu_pkg::CH_BSL, 1'b1);
            ESC_HEX:
                if (hex_cnt >= 2)
                    add_char(hex_acc, 1'b1);
                else
                begin
                    add_char(qtu_pkg::CH_BSL, 1'b1);
                    add_char(qtu_pkg::CH_LC_U, 1'b1);
                    if (hex_cnt == 1)
                        add_char(hex_acc[3:0] < 4'd10
                                 ? CH_ZERO + hex_acc[3:0]
                                 : CH_LC_A + hex_acc[3:0] - 16'd10, 1'b1);
                end
            default:
                ;
        endcase
        esc_phase = ESC_TEXT;
        hex_cnt   = 0;
        hex_acc   = '0;
    endtask

    task automatic plain_char(input logic [15:0] c);
        if (c == qtu_pkg::CH_BSL)
            esc_phase = ESC_BSL;
        else
            add_char(c, 1'b1);
    endtask

    task automatic body_char(input logic [15:0] c);
        int d;
        d = hex_nibble(c);
        case (esc_phase)
            ESC_TEXT:
                plain_char(c);
            ESC_BSL:
            begin
                esc_phase = ESC_TEXT;
                if (c == qtu_pkg::CH_BSL)
                    add_char(qtu_pkg::CH_BSL, 1'b1);
                else if (c == qtu_pkg::CH_LC_T)
                    add_char(qtu_pkg::CH_TAB, 1'b1);
                else if (c == qtu_pkg::CH_LC_N)
                    add_char(qtu_pkg::CH_LF, 1'b1);
                else if (c == qtu_pkg::CH_LC_R)
                    add_char(qtu_pkg::CH_CR, 1'b1);
                else if (c == open_quote)
                    add_char(c, 1'b1);
                else if (c == qtu_pkg::CH_LC_U)
                begin
                    esc_phase = ESC_HEX;
                    hex_cnt   = 0;
                    hex_acc   = '0;
                end
                else
                begin
                    add_char(qtu_pkg::CH_BSL, 1'b1);
                    add_char(c, 1'b1);
                end
            end
            default:
                if (d >= 0 && hex_cnt < MAX_HEX)
                begin
                    hex_acc = {hex_acc[11:0], 4'(d)};
                    hex_cnt++;
                    if (hex_cnt >= MAX_HEX)
                    begin
                        add_char(hex_acc, 1'b1);
                        esc_phase = ESC_TEXT;
                        hex_cnt   = 0;
                        hex_acc   = '0;
                    end
                end
                else
                begin
                    // The breaking character is ordinary text after the literal escape.
                    flush_escape();
                    plain_char(c);
                end
        endcase
    endtask

    task automatic unescape_char(input logic [15:0] c, input logic last);
        decoded_t r;
        step_n = 0;
        if (at_start)
        begin
            at_start  = 1'b0;
            esc_phase = ESC_TEXT;
            hex_cnt   = 0;
            hex_acc   = '0;
            if (c == qtu_pkg::CH_SQUOT || c == qtu_pkg::CH_DQUOT)
            begin
                in_quotes  = 1'b1;
                open_quote = c;
            end
            else
            begin
                in_quotes  = 1'b0;
                open_quote = '0;
                add_char(c, 1'b1);
            end
        end
        else if (!in_quotes)
            add_char(c, 1'b1);
        else if (last && c == open_quote)
            flush_escape();
        else
        begin
            body_char(c);
            if (last)
                flush_escape();
        end
        if (last)
        begin
            if (step_n == 0)
                add_char('0, 1'b0);
            reset_decoder();
        end
        if (step_n > qtu_pkg::NUM_RES)
            step_n = qtu_pkg::NUM_RES;
        for (int k = 0; k < step_n; k++)
        begin
            r.char_out   = step_char[k];
            r.char_valid = step_valid[k];
            r.run_last   = (k == step_n - 1);
            r.token_end  = last && (k == step_n - 1);
            owed_chars.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_decoder();
            owed_chars.delete();
            owed_count <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (owed_chars.size() == 0)
                    report_mismatch($sformatf("unexpected result char_out=%h", m_tdata));
                else
                begin
                    want = owed_chars.pop_front();
                    if (m_tdata !== want.char_out)
                        report_mismatch($sformatf("char_out %h, predicted %h",
                                                  m_tdata, want.char_out));
                    if (m_tuser[0] !== want.char_valid)
                        report_mismatch($sformatf("char_valid %b, predicted %b",
                                                  m_tuser[0], want.char_valid));
                    if (m_tlast !== want.run_last)
                        report_mismatch($sformatf("run_last %b, predicted %b",
                                                  m_tlast, want.run_last));
                    if (m_tuser[1] !== want.token_end)
                        report_mismatch($sformatf("token_end %b, predicted %b",
                                                  m_tuser[1], want.token_end));
                end
            end
            if (s_tvalid && s_tready)
                unescape_char(s_tdata, s_tlast);
            owed_count <= owed_chars.size();
        end
    end

endmodule

// ----- bench/testbench.sv -----
// Top of the bench: clock, reset, token stimulus with flow control, and the verdict.
`timescale 1ns / 100ps

module testbench;

    localparam int          ITEMS        = 450;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 12;
    localparam logic [15:0] CH_ZERO      = 16'h0030;
    localparam logic [15:0] CH_LC_A      = 16'h0061;
    localparam logic [15:0] CH_UC_A      = 16'h0041;
    localparam logic [15:0] CH_LC_X      = 16'h0078;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [15:0] char_in
    logic        s_tlast;    // is_last
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [15:0] char_out
    logic        m_tlast;    // run_last
    logic [1:0]  m_tuser;    // [0] char_valid, [1] token_end

    int          fail_count;
    int          owed_count;
    int          sent;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_requests;
    int          holds_done;
    logic [15:0] token_q [$];

    quoted_token_unescape u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    token_decode_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .owed_count (owed_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: random back-pressure, plus a long hold when the stimulus asks for one.
    initial
    begin
        m_tready   = 1'b0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                holds_done++;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [15:0] hex_digit_char(input int v);
        return v < 10 ? CH_ZERO + 16'(v) : CH_LC_A + 16'(v - 10);
    endfunction

    // Mostly valid lowercase digits; now and then something that breaks the escape.
    function automatic logic [15:0] random_hex_char();
        case ($urandom_range(9))
            0:       return CH_UC_A + 16'($urandom_range(5));
            1:       return 16'($urandom_range(16'hFFFF));
            default: return hex_digit_char($urandom_range(15));
        endcase
    endfunction

    function automatic logic [15:0] escape_letter(input logic [15:0] quote);
        case ($urandom_range(5))
            0:       return qtu_pkg::CH_LC_T;
            1:       return qtu_pkg::CH_LC_N;
            2:       return qtu_pkg::CH_LC_R;
            3:       return qtu_pkg::CH_BSL;
            4:       return quote;
            default: return quote == qtu_pkg::CH_SQUOT ? qtu_pkg::CH_DQUOT : qtu_pkg::CH_SQUOT;
        endcase
    endfunction

    task automatic send_char(input logic [15:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_token();
        for (int i = 0; i < token_q.size(); i++)
            send_char(token_q[i], i == token_q.size() - 1);
    endtask

    task automatic build_quoted_token();
        logic [15:0] quote;
        int          digits;
        quote = $urandom_range(1) ? qtu_pkg::CH_SQUOT : qtu_pkg::CH_DQUOT;
        token_q.delete();
        token_q.push_back(quote);
        repeat ($urandom_range(5))
        begin
            case ($urandom_range(5))
                0:
                    token_q.push_back(16'($urandom_range(16'hFFFF)));
                1:
                    token_q.push_back(16'($urandom_range(16'h20, 16'h7E)));
                2:
                begin
                    token_q.push_back(qtu_pkg::CH_BSL);
                    token_q.push_back(escape_letter(quote));
                end
                3:
                begin
                    token_q.push_back(qtu_pkg::CH_BSL);
                    token_q.push_back(16'($urandom_range(16'hFFFF)));
                end
                default:
                begin
                    token_q.push_back(qtu_pkg::CH_BSL);
                    token_q.push_back(qtu_pkg::CH_LC_U);
                    digits = $urandom_range(5);
                    repeat (digits) token_q.push_back(random_hex_char());
                end
            endcase
        end
        case ($urandom_range(9))
            0:       ;
            1:       token_q.push_back(qtu_pkg::CH_BSL);
            default: token_q.push_back(quote);
        endcase
    endtask

    task automatic build_plain_token();
        logic [15:0] c;
        token_q.delete();
        c = 16'($urandom_range(16'hFFFF));
        if (c == qtu_pkg::CH_SQUOT || c == qtu_pkg::CH_DQUOT)
            c = CH_LC_X;
        token_q.push_back(c);
        repeat ($urandom_range(5))
            token_q.push_back($urandom_range(4) == 0 ? qtu_pkg::CH_BSL
                                                     : 16'($urandom_range(16'hFFFF)));
    endtask

    // Broken sequences: random mixes of quotes, backslashes, u, digits and arbitrary characters.
    task automatic build_noise_token();
        token_q.delete();
        token_q.push_back($urandom_range(1) ? qtu_pkg::CH_SQUOT : qtu_pkg::CH_DQUOT);
        repeat ($urandom_range(7))
        begin
            case ($urandom_range(5))
                0:       token_q.push_back(qtu_pkg::CH_BSL);
                1:       token_q.push_back(qtu_pkg::CH_LC_U);
                2:       token_q.push_back(random_hex_char());
                3:       token_q.push_back($urandom_range(1) ? qtu_pkg::CH_SQUOT
                                                             : qtu_pkg::CH_DQUOT);
                default: token_q.push_back(16'($urandom_range(16'hFFFF)));
            endcase
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        sent          = 0;
        send_idle_pct = 25;
        recv_idle_pct = 55;
        hold_requests = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, a lone quote, every escape, and escapes cut short.
        token_q = '{16'hFFFF, 16'h0000};
        send_token();
        token_q = '{qtu_pkg::CH_SQUOT};
        send_token();
        token_q = '{qtu_pkg::CH_DQUOT, qtu_pkg::CH_BSL, qtu_pkg::CH_LC_T,
                    qtu_pkg::CH_BSL, qtu_pkg::CH_LC_N, qtu_pkg::CH_BSL, qtu_pkg::CH_LC_R,
                    qtu_pkg::CH_BSL, qtu_pkg::CH_BSL, qtu_pkg::CH_BSL, qtu_pkg::CH_DQUOT,
                    qtu_pkg::CH_BSL, qtu_pkg::CH_DQUOT};
        send_token();
        token_q = '{qtu_pkg::CH_SQUOT, qtu_pkg::CH_BSL, qtu_pkg::CH_LC_U,
                    hex_digit_char(7), CH_LC_X,
                    qtu_pkg::CH_BSL, qtu_pkg::CH_LC_U, hex_digit_char(15),
                    hex_digit_char(15), hex_digit_char(15), hex_digit_char(15),
                    qtu_pkg::CH_BSL, qtu_pkg::CH_LC_U, hex_digit_char(10)};
        send_token();

        while (sent < ITEMS)
        begin
            if (sent < 150)
            begin
                send_idle_pct = 25;
                recv_idle_pct = 55;
            end
            else if (sent < 300)
            begin
                send_idle_pct = 55;
                recv_idle_pct = 25;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // One long receiver hold while requests keep coming, to fill the block.
                if (hold_requests == 0)
                    hold_requests = 1;
            end
            case ($urandom_range(19))
                14, 15, 16: build_plain_token();
                17, 18, 19: build_noise_token();
                default:    build_quoted_token();
            endcase
            send_token();
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (owed_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
